@@ hw/rtl/awm_pkg.sv @@
// shared types and constants for the anagram window matcher
package awm_pkg;

   localparam int LETTER_W = 5;

   typedef enum logic [1:0] {
      CMD_CLEAR   = 2'd0,
      CMD_PATTERN = 2'd1,
      CMD_TEXT    = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_TOO_LONG = 2'd1,
      STATUS_LATE     = 2'd2
   } status_type;

   typedef struct packed {
      logic [1:0]          command;
      logic [LETTER_W-1:0] letter;
   } req_type;

   typedef struct packed {
      logic       found;
      logic       any_found;
      logic [1:0] status;
   } rsp_type;

   // per-letter balance lane control and match flags
   typedef struct packed {
      logic clear;
      logic pat;
      logic add;
      logic drop;
   } lane_ctl_type;

   typedef struct packed {
      logic inc;
      logic dec;
   } lane_flag_type;

endpackage

@@ hw/rtl/awm_lane.sv @@
// one letter's balance counter with its match gain and loss flags
module awm_lane #(
   parameter int BAL_W = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  awm_pkg::lane_ctl_type  ctl,
   output awm_pkg::lane_flag_type flag
);

   logic signed [BAL_W-1:0] bal_ff;
   logic signed [BAL_W-1:0] bal_in;
   logic signed [BAL_W-1:0] after_add;

   always_comb begin
      // text letter enters first, then the old letter leaves
      after_add = bal_ff - $signed(BAL_W'(ctl.add));
      bal_in    = after_add + $signed(BAL_W'(ctl.drop)) + $signed(BAL_W'(ctl.pat));
      flag.inc  = ctl.add & ~after_add[BAL_W-1];
      flag.dec  = ctl.drop & ~bal_in[BAL_W-1] & (bal_in != '0);
   end

   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         bal_ff <= '0;
      end else if (ctl.add || ctl.drop || ctl.pat) begin
         bal_ff <= bal_in;
      end
   end

endmodule

@@ hw/rtl/awm_ring.sv @@
// ring of recent text letters with a prefetched read of the leaving letter
module awm_ring #(
   parameter int MAX_PATTERN = 64,
   parameter int PTR_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1,
   parameter int LEN_W = $clog2(MAX_PATTERN + 1)
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [PTR_W-1:0]             wr_addr,
   input  logic [awm_pkg::LETTER_W-1:0] wr_letter,
   input  logic [PTR_W-1:0]             next_ptr,
   input  logic [LEN_W-1:0]             next_len,
   output logic [awm_pkg::LETTER_W-1:0] back_letter
);

   logic [awm_pkg::LETTER_W-1:0] mem [MAX_PATTERN];
   logic [awm_pkg::LETTER_W-1:0] back_letter_ff;
   logic [LEN_W:0]               wide_ptr;
   logic [LEN_W:0]               wide_back;
   logic [PTR_W-1:0]             rd_addr;

   // slot pattern-length positions behind the next write slot
   always_comb begin
      wide_ptr = (LEN_W + 1)'(next_ptr);
      if (wide_ptr >= (LEN_W + 1)'(next_len)) begin
         wide_back = wide_ptr - (LEN_W + 1)'(next_len);
      end else begin
         wide_back = wide_ptr + (LEN_W + 1)'(MAX_PATTERN) - (LEN_W + 1)'(next_len);
      end
      rd_addr = wide_back[PTR_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_letter;
      end
   end

   // write-first: a read of the slot being written this cycle returns the new letter
   always_ff @(posedge clock) begin
      if (wr_en && (wr_addr == rd_addr)) begin
         back_letter_ff <= wr_letter;
      end else begin
         back_letter_ff <= mem[rd_addr];
      end
   end

   assign back_letter = back_letter_ff;

endmodule

@@ hw/rtl/anagram_window_matcher_unit.sv @@
// top level of the sliding window anagram matcher
//
// The req channel carries one item per command: clear, pattern letter or
// text letter. Each accepted item gives exactly one item on the rsp channel,
// in order: found, the sticky any_found and a status code.
// An accepted item is held in an input register and is processed from there
// into the result register, which raises rsp_valid; the result is taken from
// there when the receiver is not stalling.
// Throughput is one item per cycle while rsp_ready is high: balance updates,
// the match count and the leaving letter's read all fit between the registers,
// and that letter is read ahead from the ring the cycle before it is needed.
// When rsp_ready is low the result register holds its item; one more item
// can wait in the input register, after which req_ready drops.
// Synchronous reset empties both registers and returns every counter and
// balance to zero, the same as a clear command; the letter ring needs no
// clearing since a slot is read only after it was written since the clear.
// A clear command gives a result like any other item.
module anagram_window_matcher_unit #(
   parameter int MAX_PATTERN   = 64,
   parameter int ALPHABET_SIZE = 26
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  awm_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output awm_pkg::rsp_type rsp_data
);

   localparam int PTR_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
   localparam int LEN_W = $clog2(MAX_PATTERN + 1);
   localparam int BAL_W = $clog2(MAX_PATTERN + 1) + 1;

   logic             in_valid_ff;
   awm_pkg::req_type in_data_ff;
   logic             rsp_valid_ff;
   awm_pkg::rsp_type rsp_data_ff;
   awm_pkg::rsp_type rsp_data_in;

   logic [PTR_W-1:0] wp_ff;
   logic [PTR_W-1:0] wp_in;
   logic [LEN_W-1:0] plen_ff;
   logic [LEN_W-1:0] plen_in;
   logic [LEN_W-1:0] seen_ff;
   logic [LEN_W-1:0] seen_in;
   logic [LEN_W-1:0] matched_ff;
   logic [LEN_W-1:0] matched_in;
   logic             begun_ff;
   logic             begun_in;
   logic             sticky_ff;
   logic             sticky_in;

   logic                         advance;
   logic                         is_clear;
   logic                         is_pat;
   logic                         is_text;
   logic                         text_act;
   logic                         drop_en;
   logic                         pat_ok;
   logic                         any_inc;
   logic                         any_dec;
   logic [LEN_W-1:0]             after_inc;
   logic                         found;
   awm_pkg::status_type          status;
   logic [awm_pkg::LETTER_W-1:0] back_letter;

   awm_pkg::lane_ctl_type  lane_ctl  [ALPHABET_SIZE];
   awm_pkg::lane_flag_type lane_flag [ALPHABET_SIZE];

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // command decode
   always_comb begin
      is_clear = 1'b0;
      is_pat   = 1'b0;
      is_text  = 1'b0;
      unique case (awm_pkg::cmd_type'(in_data_ff.command))
         awm_pkg::CMD_CLEAR: begin
            is_clear = advance;
         end
         awm_pkg::CMD_PATTERN: begin
            is_pat = advance;
         end
         awm_pkg::CMD_TEXT: begin
            is_text = advance;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      text_act = is_text && (plen_ff != '0);
      drop_en  = text_act && (seen_ff >= plen_ff);
      pat_ok   = is_pat && !begun_ff && (int'(plen_ff) < MAX_PATTERN)
                 && (int'(in_data_ff.letter) < ALPHABET_SIZE);
      priority if (is_pat && begun_ff) begin
         status = awm_pkg::STATUS_LATE;
      end else if (is_pat && (int'(plen_ff) >= MAX_PATTERN)) begin
         status = awm_pkg::STATUS_TOO_LONG;
      end else begin
         status = awm_pkg::STATUS_OK;
      end
   end

   always_comb begin
      for (int i = 0; i < ALPHABET_SIZE; i++) begin
         lane_ctl[i].clear = is_clear;
         lane_ctl[i].pat   = pat_ok && (int'(in_data_ff.letter) == i);
         lane_ctl[i].add   = text_act && (int'(in_data_ff.letter) == i);
         lane_ctl[i].drop  = drop_en && (int'(back_letter) == i);
      end
   end

   generate
      for (genvar g = 0; g < ALPHABET_SIZE; g++) begin : g_lane
         awm_lane #(
            .BAL_W (BAL_W)
         ) u_lane (
            .clock (clock),
            .reset (reset),
            .ctl   (lane_ctl[g]),
            .flag  (lane_flag[g])
         );
      end
   endgenerate

   always_comb begin
      any_inc = 1'b0;
      any_dec = 1'b0;
      for (int i = 0; i < ALPHABET_SIZE; i++) begin
         any_inc = any_inc | lane_flag[i].inc;
         any_dec = any_dec | lane_flag[i].dec;
      end
   end

   // next state of the window counters
   always_comb begin
      wp_in      = wp_ff;
      plen_in    = plen_ff;
      seen_in    = seen_ff;
      matched_in = matched_ff;
      begun_in   = begun_ff;
      sticky_in  = sticky_ff;
      found      = 1'b0;
      after_inc  = matched_ff + LEN_W'(any_inc);
      if (is_clear) begin
         wp_in      = '0;
         plen_in    = '0;
         seen_in    = '0;
         matched_in = '0;
         begun_in   = 1'b0;
         sticky_in  = 1'b0;
      end else if (pat_ok) begin
         plen_in = plen_ff + LEN_W'(1);
      end else if (is_text) begin
         begun_in = 1'b1;
         if (plen_ff == '0) begin
            found = 1'b1;
         end else begin
            matched_in = (any_dec && (after_inc != '0)) ? after_inc - LEN_W'(1) : after_inc;
            seen_in    = drop_en ? seen_ff : seen_ff + LEN_W'(1);
            wp_in      = (wp_ff == PTR_W'(MAX_PATTERN - 1)) ? '0 : wp_ff + PTR_W'(1);
            found      = (seen_in == plen_ff) && (matched_in == plen_ff);
         end
         if (found) begin
            sticky_in = 1'b1;
         end
      end
      rsp_data_in.found     = found;
      rsp_data_in.any_found = sticky_in;
      rsp_data_in.status    = status;
   end

   awm_ring #(
      .MAX_PATTERN (MAX_PATTERN),
      .PTR_W       (PTR_W),
      .LEN_W       (LEN_W)
   ) u_ring (
      .clock       (clock),
      .wr_en       (text_act),
      .wr_addr     (wp_ff),
      .wr_letter   (in_data_ff.letter),
      .next_ptr    (wp_in),
      .next_len    (plen_in),
      .back_letter (back_letter)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff      <= '0;
         plen_ff    <= '0;
         seen_ff    <= '0;
         matched_ff <= '0;
         begun_ff   <= 1'b0;
         sticky_ff  <= 1'b0;
      end else begin
         wp_ff      <= wp_in;
         plen_ff    <= plen_in;
         seen_ff    <= seen_in;
         matched_ff <= matched_in;
         begun_ff   <= begun_in;
         sticky_ff  <= sticky_in;
      end
   end

   // input register and result register handshakes
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

@@ bench/testbench.sv @@
// self-checking testbench for the sliding window anagram matcher
module testbench;

   localparam int MAXP        = 64;
   localparam int ALPHA       = 26;
   localparam int RANDOM_N    = 1950;
   localparam int STALL_LIMIT = 2000;
   localparam int TAIL_CYCLES = 16;
   localparam int CALM_LO     = 800;
   localparam int CALM_HI     = 1300;
   localparam int HOLD_AT     = 400;
   localparam int HOLD_LEN    = 250;
   localparam int DIR_N       = 22;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   typedef logic [awm_pkg::LETTER_W-1:0] letter_type;

   typedef struct packed {
      logic [1:0]       command;
      letter_type       letter;
      logic             typed;
      awm_pkg::rsp_type rsp;
   } dir_row_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   awm_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   awm_pkg::rsp_type rsp_data;

   anagram_window_matcher_unit #(
      .MAX_PATTERN  (MAXP),
      .ALPHABET_SIZE(ALPHA)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // directed items, typed result only where it is obvious
   dir_row_type dir_rows [DIR_N] = '{
      '{awm_pkg::CMD_TEXT,    5'd0,  1'b1, '{1'b1, 1'b1, awm_pkg::STATUS_OK}},   // empty pattern
      '{awm_pkg::CMD_CLEAR,   5'd0,  1'b1, '{1'b0, 1'b0, awm_pkg::STATUS_OK}},
      '{awm_pkg::CMD_PATTERN, 5'd0,  1'b1, '{1'b0, 1'b0, awm_pkg::STATUS_OK}},
      '{awm_pkg::CMD_PATTERN, 5'd1,  1'b1, '{1'b0, 1'b0, awm_pkg::STATUS_OK}},
      '{awm_pkg::CMD_PATTERN, 5'd31, 1'b1, '{1'b0, 1'b0, awm_pkg::STATUS_OK}},   // outside alphabet
      '{CMD_UNUSED,           5'd31, 1'b1, '{1'b0, 1'b0, awm_pkg::STATUS_OK}},
      '{awm_pkg::CMD_TEXT,    5'd1,  1'b0, '0},
      '{awm_pkg::CMD_TEXT,    5'd0,  1'b0, '0},
      '{awm_pkg::CMD_TEXT,    5'd25, 1'b0, '0},
      '{awm_pkg::CMD_PATTERN, 5'd2,  1'b1, '{1'b0, 1'b1, awm_pkg::STATUS_LATE}},
      '{awm_pkg::CMD_TEXT,    5'd1,  1'b0, '0},
      '{awm_pkg::CMD_TEXT,    5'd0,  1'b0, '0},
      '{awm_pkg::CMD_TEXT,    5'd30, 1'b0, '0},
      '{awm_pkg::CMD_CLEAR,   5'd31, 1'b1, '{1'b0, 1'b0, awm_pkg::STATUS_OK}},
      '{awm_pkg::CMD_PATTERN, 5'd25, 1'b1, '{1'b0, 1'b0, awm_pkg::STATUS_OK}},
      '{awm_pkg::CMD_TEXT,    5'd26, 1'b0, '0},
      '{awm_pkg::CMD_TEXT,    5'd25, 1'b0, '0},
      '{CMD_UNUSED,           5'd0,  1'b1, '{1'b0, 1'b1, awm_pkg::STATUS_OK}},
      '{awm_pkg::CMD_CLEAR,   5'd0,  1'b1, '{1'b0, 1'b0, awm_pkg::STATUS_OK}},
      '{awm_pkg::CMD_TEXT,    5'd31, 1'b1, '{1'b1, 1'b1, awm_pkg::STATUS_OK}},
      '{awm_pkg::CMD_PATTERN, 5'd0,  1'b1, '{1'b0, 1'b1, awm_pkg::STATUS_LATE}},
      '{awm_pkg::CMD_CLEAR,   5'd0,  1'b1, '{1'b0, 1'b0, awm_pkg::STATUS_OK}}
   };

   // window state of the predictor
   int         balance [ALPHA];
   letter_type ring [MAXP];
   int         wr_ptr;
   int         pat_len;
   int         text_cnt;
   int         hit_cnt;
   bit         text_on;
   bit         ever_hit;

   awm_pkg::rsp_type pending_results [$];
   int               sent_count;
   int               error_count;
   int               stall_cycles = 0;

   function automatic void clear_window();
      foreach (balance[i]) balance[i] = 0;
      foreach (ring[i]) ring[i] = '0;
      wr_ptr   = 0;
      pat_len  = 0;
      text_cnt = 0;
      hit_cnt  = 0;
      text_on  = 1'b0;
      ever_hit = 1'b0;
   endfunction

   function automatic awm_pkg::rsp_type match_window(awm_pkg::req_type item);
      awm_pkg::rsp_type r;
      int               back;
      letter_type       gone;
      r = '0;
      case (item.command)
         awm_pkg::CMD_CLEAR: begin
            clear_window();
         end
         awm_pkg::CMD_PATTERN: begin
            if (text_on) begin
               r.status = awm_pkg::STATUS_LATE;
            end else if (pat_len >= MAXP) begin
               r.status = awm_pkg::STATUS_TOO_LONG;
            end else if (item.letter < ALPHA) begin
               balance[item.letter]++;
               pat_len++;
            end
         end
         awm_pkg::CMD_TEXT: begin
            text_on = 1'b1;
            if (pat_len == 0) begin
               r.found = 1'b1;
            end else begin
               if (item.letter < ALPHA) begin
                  balance[item.letter]--;
                  if (balance[item.letter] >= 0) hit_cnt++;
               end
               // letter leaving the window gives its balance back
               if (text_cnt >= pat_len) begin
                  back = (wr_ptr + MAXP - pat_len) % MAXP;
                  gone = ring[back];
                  if (gone < ALPHA) begin
                     balance[gone]++;
                     if (balance[gone] > 0 && hit_cnt > 0) hit_cnt--;
                  end
               end else begin
                  text_cnt++;
               end
               ring[wr_ptr] = item.letter;
               wr_ptr = (wr_ptr + 1) % MAXP;
               r.found = (text_cnt == pat_len && hit_cnt == pat_len);
            end
            if (r.found) ever_hit = 1'b1;
         end
         default: ;
      endcase
      r.any_found = ever_hit;
      return r;
   endfunction

   task automatic send_item(logic [1:0] command, letter_type letter, bit typed,
                            awm_pkg::rsp_type typed_rsp);
      awm_pkg::req_type item;
      awm_pkg::rsp_type want;
      item.command = command;
      item.letter  = letter;
      if ((sent_count < CALM_LO || sent_count >= CALM_HI) && $urandom_range(99) < 16) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(3, 1)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      want = match_window(item);
      pending_results.insert(pending_results.size(), typed ? typed_rsp : want);
      sent_count++;
   endtask

   task automatic send_noise();
      send_item(2'($urandom_range(3, 0)), letter_type'($urandom_range(31, 0)), 1'b0, '0);
   endtask

   // clear, load a pattern, then a text rich in permutations of it
   task automatic run_session();
      letter_type pat [$];
      letter_type perm [$];
      letter_type tmp;
      letter_type pick;
      int         sel;
      int         plen;
      int         tlen;
      int         span;
      int         made;
      int         j;
      int         k;
      sel  = $urandom_range(99);
      span = $urandom_range(ALPHA - 1, 1);
      if (sel < 5) plen = 0;
      else if (sel < 12) plen = $urandom_range(MAXP + 4, MAXP - 4);
      else plen = $urandom_range(8, 1);
      send_item(awm_pkg::CMD_CLEAR, letter_type'($urandom_range(31, 0)), 1'b0, '0);
      for (k = 0; k < plen; k++) begin
         if ($urandom_range(99) < 4) pick = letter_type'($urandom_range(31, ALPHA));
         else pick = letter_type'($urandom_range(span, 0));
         send_item(awm_pkg::CMD_PATTERN, pick, 1'b0, '0);
         if (pick < ALPHA && pat.size() < MAXP) pat.insert(pat.size(), pick);
      end
      tlen = (plen > 8) ? $urandom_range(3 * MAXP, MAXP) : $urandom_range(40, 8);
      made = 0;
      while (made < tlen) begin
         sel = $urandom_range(99);
         if (sel < 55 && pat.size() > 0) begin
            perm = pat;
            for (j = perm.size() - 1; j > 0; j--) begin
               k = $urandom_range(j, 0);
               tmp = perm[j];
               perm[j] = perm[k];
               perm[k] = tmp;
            end
            if ($urandom_range(99) < 20)
               perm[$urandom_range(perm.size() - 1, 0)] = letter_type'($urandom_range(span, 0));
            foreach (perm[i]) send_item(awm_pkg::CMD_TEXT, perm[i], 1'b0, '0);
            made += perm.size();
         end else if (sel < 58) begin
            send_item(awm_pkg::CMD_PATTERN, letter_type'($urandom_range(31, 0)), 1'b0, '0);
         end else if (sel < 60) begin
            send_item(CMD_UNUSED, letter_type'($urandom_range(31, 0)), 1'b0, '0);
         end else begin
            if (sel < 64) pick = letter_type'($urandom_range(31, ALPHA));
            else if (sel < 80 || pat.size() == 0) pick = letter_type'($urandom_range(span, 0));
            else pick = pat[$urandom_range(pat.size() - 1, 0)];
            send_item(awm_pkg::CMD_TEXT, pick, 1'b0, '0);
            made++;
         end
      end
   endtask

   initial begin : req_side
      int start;
      sent_count  = 0;
      error_count = 0;
      clear_window();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      foreach (dir_rows[i])
         send_item(dir_rows[i].command, dir_rows[i].letter, dir_rows[i].typed, dir_rows[i].rsp);
      start = sent_count;
      while (sent_count - start < RANDOM_N) begin
         if ($urandom_range(99) < 85) run_session();
         else send_noise();
      end
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin : rsp_side
      int               got;
      int               hold;
      awm_pkg::rsp_type want;
      got  = 0;
      hold = 0;
      wait (reset == 1'b0);
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               if (error_count < 10) $display("unexpected item: %p", rsp_data);
               error_count++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_data.found !== want.found || rsp_data.any_found !== want.any_found ||
                   rsp_data.status !== want.status) begin
                  if (error_count < 10)
                     $display("mismatch at result %0d: expected found=%b any=%b status=%0d,",
                              got, want.found, want.any_found, want.status,
                              " got found=%b any=%b status=%0d",
                              rsp_data.found, rsp_data.any_found, rsp_data.status);
                  error_count++;
               end
            end
            got++;
            // long hold-off so the block backs up into its input
            if (got == HOLD_AT) hold = HOLD_LEN;
         end
         if (hold > 0) begin
            hold--;
            rsp_ready <= 1'b0;
         end else if (got >= CALM_LO && got < CALM_HI) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(99) >= 16);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

endmodule

@@ filelist.f @@
hw/rtl/awm_pkg.sv
hw/rtl/awm_lane.sv
hw/rtl/awm_ring.sv
hw/rtl/anagram_window_matcher_unit.sv
bench/testbench.sv
